FILE: design/fcs_pkg.sv
package fcs_pkg;

   localparam int ADDR_W        = 19;
   localparam int DATA_W        = 8;
   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 8;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [31:0] UNLOCK_ADDR_1 = 32'h0000_0aaa;
   localparam logic [31:0] UNLOCK_ADDR_2 = 32'h0000_0555;

   localparam logic [DATA_W-1:0] UNLOCK_DATA_1 = 8'haa;
   localparam logic [DATA_W-1:0] UNLOCK_DATA_2 = 8'h55;
   localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'ha0;
   localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
   localparam logic [DATA_W-1:0] CMD_RESET     = 8'hf0;
   localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hff;
   localparam logic [DATA_W-1:0] ERASE_STATUS  = 8'h80;

   localparam logic [31:0] ERASE_BLK_LOW   = 32'h0000_0000;
   localparam logic [31:0] ERASE_BLK_2     = 32'h0002_0000;
   localparam logic [31:0] ERASE_BLK_3     = 32'h0003_0000;
   localparam logic [31:0] ERASE_LEN_SMALL = 32'h0000_8000;
   localparam logic [31:0] ERASE_LEN_LARGE = 32'h0001_0000;

endpackage

FILE: design/flash_command_sequencer_core.sv
// NOR flash command interface on a byte bus, one access per transfer.
// req channel: tuser is the access kind (read or write), tdata carries the
// byte address and the write data. rsp channel: one transfer per request,
// tdata is the read byte (zero on writes), tuser flags an unknown command.
// Command decoding follows the usual AA/55 unlock sequences for program
// and block erase; F0 returns to read mode.
// A write's answer and the erase status read are registered straight
// into the output register; a store read first passes the synchronous
// store read register and the ST_READ state. Writes sustain one per cycle
// while the receiver does not stall; after a store read no new request is
// taken until ST_READ has passed. Block erase walks 32768 or 65536 bytes
// one byte per cycle (cut at the end of the store), req_tready low meanwhile.
// After reset the store is written to FF, one byte per cycle, over all
// 2**ADDR_BITS bytes before req_tready first rises.
// The result sits in an output register; while the receiver stalls a new
// request is not taken until that register drains.
module flash_command_sequencer_core #(
   parameter int ADDR_BITS = 19
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fcs_pkg::REQ_TDATA_W-1:0] req_tdata,  // address[18:0], write_byte[26:19]
   input  logic                            req_tuser,  // command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fcs_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // read_byte[7:0]
   output logic                            rsp_tuser   // unknown_command
);

   localparam logic [31:0] STORE_SIZE = 32'd1 << ADDR_BITS;
   localparam logic [31:0] ADDR_MASK  = STORE_SIZE - 32'd1;
   localparam int          DW         = fcs_pkg::DATA_W;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_GOT_AA,
      PH_GOT_55,
      PH_PROG,
      PH_GOT_80,
      PH_GOT_AA2,
      PH_ERASE
   } phase_type;

   logic [DW-1:0] store_mem [STORE_SIZE];

   state_type              state_ff;
   phase_type              phase_ff;
   phase_type              phase_in;
   logic [ADDR_BITS-1:0]   sweep_addr_ff;
   logic [ADDR_BITS-1:0]   sweep_last_ff;
   logic [ADDR_BITS-1:0]   sweep_last_in;
   logic [DW-1:0]          mem_rdata_ff;
   logic                   rsp_valid_ff;
   logic [DW-1:0]          rsp_data_ff;
   logic                   rsp_user_ff;

   logic                   accept;
   logic                   is_write;
   logic [31:0]            addr32;
   logic [ADDR_BITS-1:0]   addr;
   logic [DW-1:0]          wbyte;
   logic                   unknown;
   logic                   matched;
   logic                   prog_we;
   logic                   erase_go;
   logic [31:0]            erase_len;
   logic [31:0]            erase_end;
   logic                   mem_we;
   logic                   mem_re;
   logic [ADDR_BITS-1:0]   mem_addr;
   logic [DW-1:0]          mem_wdata;
   logic                   rsp_load;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_write   = (req_tuser == fcs_pkg::CMD_WRITE);
   assign addr32     = 32'(req_tdata[fcs_pkg::ADDR_W-1:0]) & ADDR_MASK;
   assign addr       = addr32[ADDR_BITS-1:0];
   assign wbyte      = req_tdata[fcs_pkg::ADDR_W +: DW];
   assign rsp_load   = (state_ff == ST_READ) ||
                       (accept && (is_write || phase_ff == PH_ERASE));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // write command decode
   always_comb begin
      phase_in  = phase_ff;
      matched   = 1'b0;
      unknown   = 1'b0;
      prog_we   = 1'b0;
      erase_go  = 1'b0;
      erase_len = fcs_pkg::ERASE_LEN_LARGE;
      unique case (phase_ff)
         PH_GOT_AA: begin
            if (addr32 == fcs_pkg::UNLOCK_ADDR_2 && wbyte == fcs_pkg::UNLOCK_DATA_2) begin
               phase_in = PH_GOT_55;
               matched  = 1'b1;
            end
         end
         PH_GOT_55: begin
            if (addr32 == fcs_pkg::UNLOCK_ADDR_1 && wbyte == fcs_pkg::CMD_PROGRAM) begin
               phase_in = PH_PROG;
               matched  = 1'b1;
            end else if (addr32 == fcs_pkg::UNLOCK_ADDR_1 && wbyte == fcs_pkg::CMD_ERASE) begin
               phase_in = PH_GOT_80;
               matched  = 1'b1;
            end
         end
         PH_PROG: begin
            prog_we  = 1'b1;
            phase_in = PH_IDLE;
            matched  = 1'b1;
         end
         PH_GOT_80: begin
            if (addr32 == fcs_pkg::UNLOCK_ADDR_1 && wbyte == fcs_pkg::UNLOCK_DATA_1) begin
               phase_in = PH_GOT_AA2;
               matched  = 1'b1;
            end
         end
         PH_GOT_AA2: begin
            if (addr32 == fcs_pkg::UNLOCK_ADDR_2 && wbyte == fcs_pkg::UNLOCK_DATA_2) begin
               phase_in = PH_ERASE;
               matched  = 1'b1;
            end
         end
         PH_ERASE: begin
            matched = 1'b1;
            if (addr32 == fcs_pkg::ERASE_BLK_LOW) begin
               erase_go  = 1'b1;
               erase_len = fcs_pkg::ERASE_LEN_SMALL;
            end else if (addr32 == fcs_pkg::ERASE_BLK_2 || addr32 == fcs_pkg::ERASE_BLK_3) begin
               erase_go  = 1'b1;
            end
         end
         default: begin
            if (addr32 == fcs_pkg::UNLOCK_ADDR_1 && wbyte == fcs_pkg::UNLOCK_DATA_1) begin
               phase_in = PH_GOT_AA;
               matched  = 1'b1;
            end
         end
      endcase
      if (!matched) begin
         if (wbyte == fcs_pkg::CMD_RESET) begin
            phase_in = PH_IDLE;
         end else begin
            unknown = 1'b1;
         end
      end
   end

   // erase range, cut at the end of the store
   always_comb begin
      erase_end = addr32 + erase_len;
      if (erase_end > STORE_SIZE) begin
         sweep_last_in = ADDR_BITS'(STORE_SIZE - 32'd1);
      end else begin
         sweep_last_in = ADDR_BITS'(erase_end - 32'd1);
      end
   end

   // store port control
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = addr;
      mem_wdata = wbyte;
      if (state_ff == ST_SWEEP) begin
         mem_we    = 1'b1;
         mem_addr  = sweep_addr_ff;
         mem_wdata = fcs_pkg::ERASED_BYTE;
      end else if (accept && is_write && prog_we) begin
         mem_we = 1'b1;
      end else if (accept && !is_write && phase_ff != PH_ERASE) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         phase_ff      <= PH_IDLE;
         sweep_addr_ff <= '0;
         sweep_last_ff <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_SWEEP: begin
               sweep_addr_ff <= sweep_addr_ff + 1'b1;
               if (sweep_addr_ff == sweep_last_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (is_write) begin
                     phase_ff     <= phase_in;
                     rsp_data_ff  <= '0;
                     rsp_user_ff  <= unknown;
                     if (erase_go) begin
                        sweep_addr_ff <= addr;
                        sweep_last_ff <= sweep_last_in;
                        state_ff      <= ST_SWEEP;
                     end
                  end else if (phase_ff == PH_ERASE) begin
                     phase_ff     <= PH_IDLE;
                     rsp_data_ff  <= fcs_pkg::ERASE_STATUS;
                     rsp_user_ff  <= 1'b0;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               rsp_data_ff  <= mem_rdata_ff;
               rsp_user_ff  <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: design/fcs_checker.sv
module fcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fcs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // no request is taken and no response is open right after reset, while the store is written clean
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !req_tready))
      else $error("request or response open right after reset");

   // every accepted request yields a result next cycle or blocks the input
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (rsp_tvalid || !req_tready))
      else $error("request accepted without progress");

   // unknown command only on writes, which return zero data
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("unknown command flagged with nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind flash_command_sequencer_core fcs_checker u_fcs_checker (.*);
